FILE: rtl/core/ipdf_pkg.sv
// ----------------------------------------------------------------------------
// ipdf_pkg
// Shared types and constants for the IPD frame deframer.
// ----------------------------------------------------------------------------
package ipdf_pkg;

   // Parser phase
   typedef enum logic [2:0] {
      PH_I,
      PH_P,
      PH_D,
      PH_COMMA,
      PH_CHAN,
      PH_CHAN_SEP,
      PH_LEN,
      PH_DATA
   } phase_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_EMPTY    = 2'd1,
      KIND_BAD_SEP  = 2'd2,
      KIND_LEN_REJ  = 2'd3
   } kind_type;

   // One result item
   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
      logic [7:0] channel_id;
      logic [9:0] frame_length;
      logic       last;
   } rsp_type;

   // Register indexes (byte address bit 2)
   localparam logic REG_CHANNEL_PRESENT = 1'b0;
   localparam logic REG_MAX_PAYLOAD     = 1'b1;

   localparam logic       CHANNEL_PRESENT_RST = 1'b1;
   localparam logic [9:0] MAX_PAYLOAD_RST     = 10'd999;

   // Header and separator characters
   localparam logic [7:0] CH_I     = 8'h49;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

endpackage

FILE: rtl/core/ipd_frame_deframer.sv
// ----------------------------------------------------------------------------
// ipd_frame_deframer
// Extracts +IPD style frames from a received modem byte stream.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------------
//  req      | in        | req_valid/req_stall  | req_rx_byte
//  rsp      | out       | rsp_valid/rsp_stall  | rsp_kind, rsp_payload_byte,
//           |           |                      | rsp_channel_id, rsp_frame_length,
//           |           |                      | rsp_last
//  csr      | in/out    | psel/penable/pready  | paddr, pwdata, prdata
//
//  One request per cycle while req_stall is low: each byte is one parser step,
//  fully resolved in the cycle it is accepted; the result (if any) lands in
//  the first free output entry. A two-entry output (result register plus skid
//  register) decouples the sides: req_stall is simply "skid full", so it is
//  registered and bytes keep flowing while a single result waits on rsp_stall.
//  Reset (synchronous, active high) returns the parser to hunting for I,
//  empties both output entries and restores the register defaults.
//  No clearing pass; the block takes requests the cycle after reset drops.
// ----------------------------------------------------------------------------
module ipd_frame_deframer
   import ipdf_pkg::*;
#(
   parameter int LEN_CHARS = 3          // length characters, 1..4
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_channel_id,
   output logic [9:0]  rsp_frame_length,
   output logic        rsp_last,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // Accumulator holds up to 10^LEN_CHARS - 1 (< 16^LEN_CHARS), and at least
   // the width of max_payload so the limit compare is direct.
   localparam int ACC_W = (4 * LEN_CHARS > 10) ? 4 * LEN_CHARS : 10;
   localparam int CNT_W = $clog2(LEN_CHARS + 1);

   // ---------------------------------------------------------------- config
   logic       chan_present_ff;
   logic [9:0] max_payload_ff;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_present_ff <= CHANNEL_PRESENT_RST;
         max_payload_ff  <= MAX_PAYLOAD_RST;
      end else if (csr_write) begin
         if (paddr[2] == REG_CHANNEL_PRESENT) begin
            chan_present_ff <= pwdata[0];
         end else begin
            max_payload_ff <= pwdata[9:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_MAX_PAYLOAD) begin
         prdata = {22'd0, max_payload_ff};
      end else begin
         prdata = {31'd0, chan_present_ff};
      end
   end

   // ---------------------------------------------------------- parser state
   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             neg_ff, neg_in;
   logic             stop_ff, stop_in;     // first non-digit seen
   logic             start_ff, start_in;   // sign, digit or stop character seen
   logic [7:0]       chan_ff, chan_in;
   logic [9:0]       left_ff, left_in;     // payload bytes still to come
   logic [9:0]       flen_ff, flen_in;

   // Output register and skid register
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;
   logic             skid_valid_ff, skid_valid_in;
   rsp_type          skid_ff, skid_in;

   logic             req_fire;
   logic             out_take;
   logic             res_valid;
   rsp_type          res;

   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid && !skid_valid_ff;
   assign out_take  = out_valid_ff && !rsp_stall;

   // ---------------------------------------------- length character decode
   logic [7:0]       c;
   logic             c_colon, c_digit, c_space;
   logic [CNT_W-1:0] cnt_upd;
   logic [ACC_W-1:0] acc_upd;
   logic             neg_upd, stop_upd, start_upd;
   logic [ACC_W-1:0] fin_acc;
   logic             fin_neg;
   logic             len_end;
   logic             len_reject;

   assign c       = req_rx_byte;
   assign c_colon = (c == CH_COLON);
   assign c_digit = (c >= CH_ZERO) && (c <= CH_NINE);
   assign c_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   assign cnt_upd = cnt_ff + CNT_W'(1);

   // atoi-style: skip leading space, one optional sign, digits until a stop
   always_comb begin
      acc_upd   = acc_ff;
      neg_upd   = neg_ff;
      stop_upd  = stop_ff;
      start_upd = start_ff;
      if (!stop_ff) begin
         if (!start_ff && c_space) begin
            start_upd = 1'b0;
         end else if (!start_ff && c == CH_MINUS) begin
            start_upd = 1'b1;
            neg_upd   = 1'b1;
         end else if (!start_ff && c == CH_PLUS) begin
            start_upd = 1'b1;
         end else if (c_digit) begin
            start_upd = 1'b1;
            // acc*10 + digit, as shifts; fits by choice of ACC_W
            acc_upd   = (acc_ff << 3) + (acc_ff << 1) + ACC_W'(c[3:0]);
         end else begin
            start_upd = 1'b1;
            stop_upd  = 1'b1;
         end
      end
   end

   assign fin_acc    = c_colon ? acc_ff : acc_upd;
   assign fin_neg    = c_colon ? neg_ff : neg_upd;
   assign len_end    = c_colon || (cnt_upd == CNT_W'(LEN_CHARS));
   assign len_reject = (fin_neg && fin_acc != '0) ||
                       (fin_acc > ACC_W'(max_payload_ff));

   // ------------------------------------------------------- next state
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      stop_in  = stop_ff;
      start_in = start_ff;
      chan_in  = chan_ff;
      left_in  = left_ff;
      flen_in  = flen_ff;

      res_valid        = 1'b0;
      res.kind         = KIND_PAYLOAD;
      res.payload_byte = 8'd0;
      res.channel_id   = chan_ff;
      res.frame_length = 10'd0;
      res.last         = 1'b1;

      if (req_fire) begin
         unique case (phase_ff)
            PH_I: begin
               if (c == CH_I) phase_in = PH_P;
            end
            PH_P: begin
               phase_in = (c == CH_P) ? PH_D : PH_I;
            end
            PH_D: begin
               phase_in = (c == CH_D) ? PH_COMMA : PH_I;
            end
            PH_COMMA: begin
               if (c != CH_COMMA) begin
                  phase_in = PH_I;
               end else begin
                  chan_in  = 8'd0;
                  cnt_in   = '0;
                  acc_in   = '0;
                  neg_in   = 1'b0;
                  stop_in  = 1'b0;
                  start_in = 1'b0;
                  phase_in = chan_present_ff ? PH_CHAN : PH_LEN;
               end
            end
            PH_CHAN: begin
               chan_in  = c;
               phase_in = PH_CHAN_SEP;
            end
            PH_CHAN_SEP: begin
               if (c != CH_COMMA) begin
                  phase_in  = PH_I;
                  res_valid = 1'b1;
                  res.kind  = KIND_BAD_SEP;
               end else begin
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               cnt_in   = cnt_upd;
               acc_in   = acc_upd;
               neg_in   = neg_upd;
               stop_in  = stop_upd;
               start_in = start_upd;
               if (len_end) begin
                  if (len_reject) begin
                     phase_in  = PH_I;
                     res_valid = 1'b1;
                     res.kind  = KIND_LEN_REJ;
                  end else if (fin_acc == '0) begin
                     phase_in  = PH_I;
                     res_valid = 1'b1;
                     res.kind  = KIND_EMPTY;
                  end else begin
                     // not rejected, so it fits in 10 bits
                     phase_in = PH_DATA;
                     flen_in  = fin_acc[9:0];
                     left_in  = fin_acc[9:0];
                  end
               end
            end
            PH_DATA: begin
               left_in          = left_ff - 10'd1;
               res_valid        = 1'b1;
               res.kind         = KIND_PAYLOAD;
               res.payload_byte = c;
               res.frame_length = flen_ff;
               res.last         = (left_ff == 10'd1);
               if (left_ff == 10'd1) phase_in = PH_I;
            end
            default: begin
               phase_in = PH_I;
            end
         endcase
      end
   end

   // ------------------------------------------------------- output buffering
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // no request taken this cycle; drain skid into the output slot
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_in       = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_I;
         cnt_ff        <= '0;
         acc_ff        <= '0;
         neg_ff        <= 1'b0;
         stop_ff       <= 1'b0;
         start_ff      <= 1'b0;
         chan_ff       <= 8'd0;
         left_ff       <= 10'd0;
         flen_ff       <= 10'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         cnt_ff        <= cnt_in;
         acc_ff        <= acc_in;
         neg_ff        <= neg_in;
         stop_ff       <= stop_in;
         start_ff      <= start_in;
         chan_ff       <= chan_in;
         left_ff       <= left_in;
         flen_ff       <= flen_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_payload_byte = out_ff.payload_byte;
   assign rsp_channel_id   = out_ff.channel_id;
   assign rsp_frame_length = out_ff.frame_length;
   assign rsp_last         = out_ff.last;

   // ------------------------------------------------------------ assertions
   // skid only fills behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry without output entry");

   // a payload phase always has bytes outstanding
   a_data_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (left_ff != 10'd0))
      else $error("payload phase with zero bytes left");

   // non-payload results carry no byte and no length, and end the frame
   a_nonpayload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_PAYLOAD) |->
      (rsp_payload_byte == 8'd0 && rsp_frame_length == 10'd0 && rsp_last))
      else $error("malformed non-payload result");

   // a stalled result is not dropped
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result lost under stall");

   // a byte accepted while the skid is full would be lost
   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !req_fire)
      else $error("request taken with full skid");

endmodule
